// File: hw/rtl/etxle_pkg.sv
// Shared types and constants of the ETX link estimator table.
// No dependencies; imported by the core.
package etxle_pkg;

   localparam int ALPHA_W     = 7;
   localparam int ETX_W       = 16;
   localparam int FRESH_W     = 8;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int ACC_W       = 23;
   localparam int RECIP_W     = 26;
   localparam int RECIP_SHIFT = 32;
   localparam int RCP_W       = ACC_W + RECIP_W;

   localparam logic [ALPHA_W-1:0] PCT_SCALE  = 7'd100;
   localparam int                 ETX_START  = 2;
   localparam logic [RECIP_W-1:0] RECIP_100  = 26'd42949672;

   localparam logic [1:0] OP_TX_DONE = 2'd0;
   localparam logic [1:0] OP_RX      = 2'd1;
   localparam logic [1:0] OP_TICK    = 2'd2;

   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_NO_ACK     = 2'd1;
   localparam logic [1:0] ST_QUEUE_FULL = 2'd2;
   localparam logic [1:0] ST_ERROR      = 2'd3;

   localparam logic [1:0] RES_UPDATED    = 2'd0;
   localparam logic [1:0] RES_IGNORED    = 2'd1;
   localparam logic [1:0] RES_TABLE_FULL = 2'd2;
   localparam logic [1:0] RES_QUEUE_DROP = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_FRESH_TARGET    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRESH_MAX       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FRESH_EXPIRY    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA_NORMAL    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA_BOOTSTRAP = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_NOACK_PENALTY   = 3'd5;

   localparam logic [7:0]  RST_FRESH_TARGET    = 8'd4;
   localparam logic [7:0]  RST_FRESH_MAX       = 8'd16;
   localparam logic [31:0] RST_FRESH_EXPIRY    = 32'd76800;
   localparam logic [6:0]  RST_ALPHA_NORMAL    = 7'd10;
   localparam logic [6:0]  RST_ALPHA_BOOTSTRAP = 7'd25;
   localparam logic [5:0]  RST_NOACK_PENALTY   = 6'd12;

   typedef struct packed {
      logic [1:0]  op;
      logic [63:0] nbr_addr;
      logic [1:0]  tx_status;
      logic [5:0]  tx_tries;
      logic [31:0] now;
   } req_type;

   typedef struct packed {
      logic [3:0]  entry_index;
      logic [15:0] etx_value;
      logic [7:0]  fresh_value;
      logic [1:0]  result_code;
   } rsp_type;

   typedef struct packed {
      logic [ETX_W-1:0]   etx;
      logic [FRESH_W-1:0] fresh;
   } ent_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SEARCH,
      S_TICK,
      S_LOAD,
      S_MUL,
      S_SUM,
      S_RECIP,
      S_FIX,
      S_RESP
   } state_type;

endpackage

// File: hw/rtl/etxle_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module etxle_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/etx_link_estimator_table_core.sv
// Top level of the ETX link estimator table: neighbor lookup, EWMA update, aging.
// Depends on etxle_pkg and etxle_ram.
//
// One item at a time. A transmit-done or receive item walks the address memory one
// entry per cycle through its single read port, and the EWMA adds two multiplies, a
// reciprocal multiply by 1/100 and a correction step. An aging tick walks the entry
// memory the same way. Items ignored at decode go straight to the response state.
// Valid bits sit in flip-flops, so no clearing pass follows reset. The result waits
// in an output register, and the next item is taken from the cycle after the result
// is loaded there, even while it waits.
module etx_link_estimator_table_core import etxle_pkg::*; #(
   parameter int NUM_NEIGHBORS = 16,
   parameter int ADDR_BITS     = 64,
   parameter int ETX_DIV       = 128
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int IDX_W   = (NUM_NEIGHBORS > 1) ? $clog2(NUM_NEIGHBORS) : 1;
   localparam int CNT_W   = $clog2(NUM_NEIGHBORS + 1);
   localparam int DIV_W   = $clog2(ETX_DIV + 1);
   localparam int PKT_W   = 7 + DIV_W;
   localparam int ENT_W   = $bits(ent_type);
   localparam int Q_W     = RCP_W - RECIP_SHIFT;
   localparam logic [ETX_W-1:0] ETX_RX_INIT = ETX_W'(ETX_START * ETX_DIV);
   localparam logic [CNT_W-1:0] NUM_CNT     = CNT_W'(NUM_NEIGHBORS);

   state_type state_ff, state_in;
   req_type   req_ff, req_in;
   rsp_type   res_ff, res_in;
   rsp_type   rsp_data_ff, rsp_data_in;
   logic      rsp_valid_ff, rsp_valid_in;

   logic [CNT_W-1:0]         scan_ff, scan_in;
   logic                     pend_ff, pend_in;
   logic [IDX_W-1:0]         pend_idx_ff, pend_idx_in;
   logic                     free_fnd_ff, free_fnd_in;
   logic [IDX_W-1:0]         free_idx_ff, free_idx_in;
   logic [IDX_W-1:0]         slot_ff, slot_in;
   logic                     new_ff, new_in;
   logic [NUM_NEIGHBORS-1:0] valid_ff, valid_in;

   logic [FRESH_W-1:0] wk_fresh_ff, wk_fresh_in;
   logic [ETX_W-1:0]   wk_etx_ff, wk_etx_in;
   logic [PKT_W-1:0]   wk_pkt_ff, wk_pkt_in;
   logic [ALPHA_W-1:0] wk_alpha_ff, wk_alpha_in;
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic [RCP_W-1:0]   rcp_ff, rcp_in;

   logic [7:0]  fresh_target_ff, fresh_max_ff;
   logic [31:0] fresh_expiry_ff;
   logic [6:0]  alpha_normal_ff, alpha_bootstrap_ff;
   logic [5:0]  noack_penalty_ff;

   logic                 addr_wr_en;
   logic [IDX_W-1:0]     addr_wr_idx;
   logic [IDX_W-1:0]     addr_rd_idx;
   logic [ADDR_BITS-1:0] addr_rd_data;
   logic                 data_wr_en;
   logic [IDX_W-1:0]     data_wr_idx;
   ent_type              data_wr_val;
   logic [IDX_W-1:0]     data_rd_idx;
   ent_type              data_rd_val;

   logic               scan_live;
   logic [IDX_W-1:0]   scan_idx;
   logic               hit;
   ent_type            cur;
   logic [8:0]         f_sum;
   logic [FRESH_W-1:0] f_new;
   logic [6:0]         count;
   logic [PKT_W-1:0]   pkt;
   logic               fresh_ok;
   logic [ALPHA_W-1:0] alpha_raw;
   logic [ALPHA_W-1:0] alpha_sat;
   logic [Q_W-1:0]     q0;
   logic [ACC_W-1:0]   rem;
   logic [Q_W-1:0]     quot;
   logic [ETX_W-1:0]   etx_new;

   etxle_ram #(.WIDTH(ADDR_BITS), .DEPTH(NUM_NEIGHBORS), .AW(IDX_W)) u_addr_ram (
      .clock   (clock),
      .wr_en   (addr_wr_en),
      .wr_addr (addr_wr_idx),
      .wr_data (req_ff.nbr_addr[ADDR_BITS-1:0]),
      .rd_addr (addr_rd_idx),
      .rd_data (addr_rd_data)
   );

   etxle_ram #(.WIDTH(ENT_W), .DEPTH(NUM_NEIGHBORS), .AW(IDX_W)) u_data_ram (
      .clock   (clock),
      .wr_en   (data_wr_en),
      .wr_addr (data_wr_idx),
      .wr_data (data_wr_val),
      .rd_addr (data_rd_idx),
      .rd_data (data_rd_val)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         fresh_target_ff    <= RST_FRESH_TARGET;
         fresh_max_ff       <= RST_FRESH_MAX;
         fresh_expiry_ff    <= RST_FRESH_EXPIRY;
         alpha_normal_ff    <= RST_ALPHA_NORMAL;
         alpha_bootstrap_ff <= RST_ALPHA_BOOTSTRAP;
         noack_penalty_ff   <= RST_NOACK_PENALTY;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_FRESH_TARGET:    fresh_target_ff    <= csr_wdata[7:0];
            CSR_FRESH_MAX:       fresh_max_ff       <= csr_wdata[7:0];
            CSR_FRESH_EXPIRY:    fresh_expiry_ff    <= csr_wdata[31:0];
            CSR_ALPHA_NORMAL:    alpha_normal_ff    <= csr_wdata[6:0];
            CSR_ALPHA_BOOTSTRAP: alpha_bootstrap_ff <= csr_wdata[6:0];
            CSR_NOACK_PENALTY:   noack_penalty_ff   <= csr_wdata[5:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
         scan_ff      <= '0;
         pend_ff      <= 1'b0;
         free_fnd_ff  <= 1'b0;
         new_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         valid_ff     <= valid_in;
         scan_ff      <= scan_in;
         pend_ff      <= pend_in;
         free_fnd_ff  <= free_fnd_in;
         new_ff       <= new_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
      pend_idx_ff <= pend_idx_in;
      free_idx_ff <= free_idx_in;
      slot_ff     <= slot_in;
      wk_fresh_ff <= wk_fresh_in;
      wk_etx_ff   <= wk_etx_in;
      wk_pkt_ff   <= wk_pkt_in;
      wk_alpha_ff <= wk_alpha_in;
      acc_ff      <= acc_in;
      rcp_ff      <= rcp_in;
   end

   always_comb begin
      scan_live = (scan_ff < NUM_CNT);
      scan_idx  = scan_ff[IDX_W-1:0];
      hit       = pend_ff && valid_ff[pend_idx_ff] &&
                  (addr_rd_data == req_ff.nbr_addr[ADDR_BITS-1:0]);
      cur       = new_ff ? ent_type'('0) : data_rd_val;

      f_sum     = 9'(cur.fresh) + 9'(req_ff.tx_tries);
      f_new     = (f_sum > 9'(fresh_max_ff)) ? fresh_max_ff : f_sum[7:0];
      count     = 7'(req_ff.tx_tries) +
                  ((req_ff.tx_status == ST_NO_ACK) ? 7'(noack_penalty_ff) : 7'd0);
      pkt       = PKT_W'(count) * PKT_W'(ETX_DIV);
      fresh_ok  = (fresh_expiry_ff != 32'd0) && (f_new >= fresh_target_ff);
      alpha_raw = fresh_ok ? alpha_normal_ff : alpha_bootstrap_ff;
      alpha_sat = (alpha_raw > PCT_SCALE) ? PCT_SCALE : alpha_raw;

      q0   = rcp_ff[RCP_W-1:RECIP_SHIFT];
      rem  = acc_ff - ACC_W'(q0) * ACC_W'(PCT_SCALE);
      quot = (rem >= ACC_W'(PCT_SCALE)) ? q0 + Q_W'(1) : q0;
      etx_new = '0;

      state_in     = state_ff;
      req_in       = req_ff;
      res_in       = res_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      scan_in      = scan_ff;
      pend_in      = pend_ff;
      pend_idx_in  = pend_idx_ff;
      free_fnd_in  = free_fnd_ff;
      free_idx_in  = free_idx_ff;
      slot_in      = slot_ff;
      new_in       = new_ff;
      valid_in     = valid_ff;
      wk_fresh_in  = wk_fresh_ff;
      wk_etx_in    = wk_etx_ff;
      wk_pkt_in    = wk_pkt_ff;
      wk_alpha_in  = wk_alpha_ff;
      acc_in       = acc_ff;
      rcp_in       = rcp_ff;

      addr_wr_en  = 1'b0;
      addr_wr_idx = free_idx_ff;
      addr_rd_idx = scan_idx;
      data_wr_en  = 1'b0;
      data_wr_idx = slot_ff;
      data_wr_val = cur;
      data_rd_idx = scan_idx;

      req_ready = (state_ff == S_IDLE);

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in      = req_data;
               scan_in     = '0;
               pend_in     = 1'b0;
               free_fnd_in = 1'b0;
               new_in      = 1'b0;
               res_in      = '0;
               case (req_data.op)
                  OP_TICK: state_in = S_TICK;
                  OP_RX:   state_in = S_SEARCH;
                  OP_TX_DONE: begin
                     if (req_data.tx_status == ST_ERROR) begin
                        res_in.result_code = RES_IGNORED;
                        state_in = S_RESP;
                     end else begin
                        state_in = S_SEARCH;
                     end
                  end
                  default: begin
                     res_in.result_code = RES_IGNORED;
                     state_in = S_RESP;
                  end
               endcase
            end
         end

         S_SEARCH: begin
            if (scan_live) begin
               scan_in     = scan_ff + CNT_W'(1);
               pend_in     = 1'b1;
               pend_idx_in = scan_idx;
               if (!valid_ff[scan_idx] && !free_fnd_ff) begin
                  free_fnd_in = 1'b1;
                  free_idx_in = scan_idx;
               end
            end else begin
               pend_in = 1'b0;
            end
            if (hit) begin
               slot_in     = pend_idx_ff;
               data_rd_idx = pend_idx_ff;
               state_in    = S_LOAD;
            end else if (!pend_ff && !scan_live) begin
               if (req_ff.op == OP_TX_DONE && req_ff.tx_status != ST_OK) begin
                  res_in.result_code = RES_IGNORED;
                  state_in = S_RESP;
               end else if (!free_fnd_ff) begin
                  res_in.result_code = RES_TABLE_FULL;
                  state_in = S_RESP;
               end else begin
                  valid_in[free_idx_ff] = 1'b1;
                  addr_wr_en = 1'b1;
                  slot_in    = free_idx_ff;
                  new_in     = 1'b1;
                  state_in   = S_LOAD;
               end
            end
         end

         S_TICK: begin
            if (scan_live) begin
               scan_in     = scan_ff + CNT_W'(1);
               pend_in     = 1'b1;
               pend_idx_in = scan_idx;
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff && valid_ff[pend_idx_ff]) begin
               data_wr_en        = 1'b1;
               data_wr_idx       = pend_idx_ff;
               data_wr_val.etx   = data_rd_val.etx;
               data_wr_val.fresh = data_rd_val.fresh >> 1;
            end
            if (!pend_ff && !scan_live) begin
               res_in.result_code = RES_UPDATED;
               state_in = S_RESP;
            end
         end

         S_LOAD: begin
            res_in.entry_index = 4'(slot_ff);
            res_in.etx_value   = cur.etx;
            res_in.fresh_value = cur.fresh;
            if (req_ff.op == OP_RX) begin
               etx_new            = (cur.etx == '0) ? ETX_RX_INIT : cur.etx;
               data_wr_en         = 1'b1;
               data_wr_val.etx    = etx_new;
               res_in.etx_value   = etx_new;
               res_in.result_code = RES_UPDATED;
               state_in           = S_RESP;
            end else if (req_ff.tx_status == ST_QUEUE_FULL) begin
               res_in.result_code = RES_QUEUE_DROP;
               state_in           = S_RESP;
            end else begin
               wk_fresh_in = f_new;
               wk_etx_in   = cur.etx;
               wk_pkt_in   = pkt;
               wk_alpha_in = alpha_sat;
               if (cur.etx == '0) begin
                  etx_new            = ETX_W'(pkt);
                  data_wr_en         = 1'b1;
                  data_wr_val.etx    = etx_new;
                  data_wr_val.fresh  = f_new;
                  res_in.etx_value   = etx_new;
                  res_in.fresh_value = f_new;
                  res_in.result_code = RES_UPDATED;
                  state_in           = S_RESP;
               end else begin
                  state_in = S_MUL;
               end
            end
         end

         S_MUL: begin
            acc_in   = ACC_W'(wk_etx_ff) * ACC_W'(PCT_SCALE - wk_alpha_ff);
            state_in = S_SUM;
         end

         S_SUM: begin
            acc_in   = acc_ff + ACC_W'(wk_pkt_ff) * ACC_W'(wk_alpha_ff);
            state_in = S_RECIP;
         end

         S_RECIP: begin
            rcp_in   = RCP_W'(acc_ff) * RCP_W'(RECIP_100);
            state_in = S_FIX;
         end

         S_FIX: begin
            etx_new            = ETX_W'(quot);
            data_wr_en         = 1'b1;
            data_wr_val.etx    = etx_new;
            data_wr_val.fresh  = wk_fresh_ff;
            res_in.entry_index = 4'(slot_ff);
            res_in.etx_value   = etx_new;
            res_in.fresh_value = wk_fresh_ff;
            res_in.result_code = RES_UPDATED;
            state_in           = S_RESP;
         end

         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_full_means_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESP && res_ff.result_code == RES_TABLE_FULL) |-> (&valid_ff))
      else $error("table full reported with a free entry");

   a_write_valid_entry: assert property (@(posedge clock) disable iff (reset)
      data_wr_en |-> valid_ff[data_wr_idx])
      else $error("entry memory written at an invalid slot");

   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff != S_IDLE))
      else $error("idle right after an input transfer");

   a_valid_grows: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> ($countones(valid_ff) >= $countones($past(valid_ff))))
      else $error("valid entry lost");

endmodule
